// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

	localparam int MAP_PAGES_DEF = 65536;
	localparam int WORD_BITS_DEF = 32;
	localparam int COUNT_W       = 17;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic       OP_ALLOC = 1'b0;
	localparam logic       OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OOM   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic        op;
		logic [15:0] start_page;
		logic [16:0] run_length;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] alloc_page;
		logic [16:0] pages_in_use;
	} rsp_t;

endpackage

// ===== rtl/bpa_ram.sv =====
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/bitmap_page_allocator_next_fit_unit.sv =====
// A request is decided at once on acceptance, or the map is scanned page by page and then
// each page freed or allocated is read and written; the search restarts at page 0 when needed.
// Throughput: one request at a time; the next is accepted at the earliest in the cycle
// after the result transfer. Result held in an output register.
// Reset: map cleared word by word to all used, page_count 65536,
// pages_in_use = min(MAP_PAGES, 65536), hint 0.
module bitmap_page_allocator_next_fit_unit #(
	parameter int MAP_PAGES = bpa_pkg::MAP_PAGES_DEF,
	parameter int WORD_BITS = bpa_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [16:0]   cfg_wdata,
	input  logic          in_valid,
	output logic          in_stall,
	input  bpa_pkg::req_t in_data,
	input  logic          out_stall,
	output logic          out_valid,
	output bpa_pkg::rsp_t out_data
);
	import bpa_pkg::*;

	localparam int WORDS = (MAP_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = $clog2(WORD_BITS);
	localparam int PW    = 21;
	localparam logic [PW-1:0] NPG    = PW'(MAP_PAGES);
	localparam logic [PW-1:0] PG_CAP = PW'(65536);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_SRD  = 4'd2;
	localparam logic [3:0] S_SCHK = 4'd3;
	localparam logic [3:0] S_MRD  = 4'd4;
	localparam logic [3:0] S_MWR  = 4'd5;
	localparam logic [3:0] S_DONE = 4'd6;

	logic [3:0]    state_q;
	logic [16:0]   page_count_q;
	logic [16:0]   used_q;
	logic [15:0]   hint_q;
	logic [AW-1:0] clr_q;
	logic          op_q;
	logic          pass2_q;
	logic [PW-1:0] p_q, hi_q, end_q, s_q, run_q;
	logic [16:0]   len_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic             we;
	logic [AW-1:0]    waddr, raddr;
	logic [WORD_BITS-1:0] wdata, rdata;

	bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_map (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [PW-1:0] total;
	always_comb begin
		total = PW'(page_count_q);
		if (total > NPG) total = NPG;
		if (total > PG_CAP) total = PG_CAP;
	end

	logic [BW-1:0] bit_idx;
	logic          bit_free;
	logic [PW-1:0] run_n;
	logic [PW-1:0] run_start;
	logic [PW-1:0] used_sum;
	logic [16:0]   used_add;
	assign bit_idx   = p_q[BW-1:0];
	assign bit_free  = rdata[bit_idx];
	assign run_n     = run_q + 1'b1;
	assign run_start = p_q + 1'b1 - PW'(len_q);
	assign used_sum  = PW'(used_q) + PW'(len_q);
	assign used_add  = (used_sum > PW'(COUNT_MAX)) ? COUNT_MAX : used_sum[16:0];

	always_comb begin
		we    = 1'b0;
		waddr = p_q[BW+AW-1:BW];
		wdata = rdata;
		wdata[bit_idx] = (op_q == OP_FREE);
		raddr = p_q[BW+AW-1:BW];
		if (state_q == S_CLR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == S_MWR) begin
			we = 1'b1;
		end
	end

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic [PW-1:0] req_end;
	assign req_end = PW'(in_data.start_page) + PW'(in_data.run_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			page_count_q <= 17'h10000;
			used_q       <= (NPG < 21'h10000) ? NPG[16:0] : 17'h10000;
			hint_q       <= '0;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				page_count_q <= cfg_wdata;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(WORDS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && !out_valid_q) begin
						op_q  <= in_data.op;
						len_q <= in_data.run_length;
						if (in_data.op == OP_FREE) begin
							if (req_end > total) begin
								out_q <= '{ST_RANGE, 16'd0, used_q};
								state_q <= S_DONE;
							end else begin
								out_q  <= '{ST_OK, 16'd0, used_q};
								hint_q <= in_data.start_page;
								p_q    <= PW'(in_data.start_page);
								end_q  <= req_end;
								state_q <= (in_data.run_length == 0) ? S_DONE : S_MRD;
							end
						end else if (in_data.run_length == 0 ||
							PW'(in_data.run_length) > total) begin
							out_q <= '{ST_OOM, 16'd0, used_q};
							state_q <= S_DONE;
						end else if (PW'(hint_q) < total) begin
							out_q <= '{ST_OK, 16'd0, used_q};
							pass2_q <= 1'b0;
							p_q <= PW'(hint_q);
							hi_q <= total; run_q <= '0;
							state_q <= S_SRD;
						end else begin
							out_q <= '{ST_OK, 16'd0, used_q};
							pass2_q <= 1'b1;
							p_q <= '0;
							hi_q <= PW'(hint_q); run_q <= '0;
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					if (p_q >= total) begin
						if (!pass2_q && hint_q != 0) begin
							pass2_q <= 1'b1;
							p_q <= '0; hi_q <= PW'(hint_q); run_q <= '0;
						end else begin
							out_q <= '{ST_OOM, 16'd0, used_q};
							state_q <= S_DONE;
						end
					end else
						state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (bit_free) begin
						run_q <= run_n;
						if (run_n >= PW'(len_q)) begin
							if (run_start >= hi_q) begin
								p_q <= total;
								state_q <= S_SRD;
							end else begin
								s_q   <= run_start;
								p_q   <= run_start;
								end_q <= p_q + 1'b1;
								state_q <= S_MRD;
							end
						end else begin
							p_q <= p_q + 1'b1;
							state_q <= S_SRD;
						end
					end else begin
						run_q <= '0;
						state_q <= S_SRD;
						if (p_q + 1'b1 >= hi_q) p_q <= total;
						else p_q <= p_q + 1'b1;
					end
				end
				S_MRD: begin
					if (p_q >= end_q) begin
						if (op_q == OP_ALLOC) begin
							hint_q <= s_q[15:0];
							used_q <= used_add;
							out_q  <= '{ST_OK, s_q[15:0], used_add};
						end else
							out_q <= '{ST_OK, 16'd0, used_q};
						state_q <= S_DONE;
					end else
						state_q <= S_MWR;
				end
				S_MWR: begin
					if (op_q == OP_FREE && !bit_free && used_q != 0)
						used_q <= used_q - 1'b1;
					p_q <= p_q + 1'b1;
					state_q <= S_MRD;
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== dv/bpa_checker.sv =====
`timescale 1ns / 100ps

module bpa_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [16:0]   cfg_wdata,
	input  logic          in_valid,
	input  logic          in_stall,
	input  bpa_pkg::req_t in_data,
	input  logic          out_valid,
	input  logic          out_stall,
	input  bpa_pkg::rsp_t out_data,
	output int            errors,
	output int            done,
	output int            pending
);
	import bpa_pkg::*;

	bit                  page_free [0:65535];
	logic [16:0]         page_count;
	logic [16:0]         used_cnt;
	logic [15:0]         hint;
	rsp_t                expected_rsp [$];

	function automatic int unsigned managed_pages();
		int unsigned t;
		t = page_count;
		if (t > 65536) t = 65536;
		return t;
	endfunction

	// lowest s in [lo, hi_start) with [s, s+len) all free below total
	function automatic bit find_free_run(int unsigned lo, int unsigned hi_start,
		int unsigned len, int unsigned total, output int unsigned s);
		int unsigned p;
		int unsigned run;
		run = 0;
		for (p = lo; p < total; p++) begin
			if (page_free[p]) begin
				run++;
				if (run >= len) begin
					if (p + 1 - len >= hi_start) return 0;
					s = p + 1 - len;
					return 1;
				end
			end else begin
				run = 0;
				if (p + 1 >= hi_start) return 0;
			end
		end
		return 0;
	endfunction

	function automatic rsp_t serve_request(req_t r);
		rsp_t        o;
		int unsigned total;
		int unsigned len;
		int unsigned s;
		int unsigned cnt;
		bit          found;
		total = managed_pages();
		len = r.run_length;
		o = '0;
		found = 0;
		s = 0;
		if (r.op == OP_ALLOC) begin
			if (len != 0 && len <= total) begin
				if (hint < total) found = find_free_run(hint, total, len, total, s);
				if (!found && hint > 0) found = find_free_run(0, hint, len, total, s);
			end
			if (found) begin
				for (int unsigned p = s; p < s + len; p++) page_free[p] = 0;
				cnt = used_cnt + len;
				used_cnt = (cnt > COUNT_MAX) ? COUNT_MAX : cnt[16:0];
				hint = s[15:0];
				o.alloc_page = s[15:0];
				o.status = ST_OK;
			end else begin
				o.status = ST_OOM;
			end
		end else begin
			if (r.start_page + len > total) begin
				o.status = ST_RANGE;
			end else begin
				for (int unsigned p = r.start_page; p < r.start_page + len; p++) begin
					if (!page_free[p]) begin
						if (used_cnt > 0) used_cnt--;
						page_free[p] = 1;
					end
				end
				hint = r.start_page;
				o.status = ST_OK;
			end
		end
		o.pages_in_use = used_cnt;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			for (int i = 0; i < 65536; i++) page_free[i] = 0;
			page_count = 17'h10000;
			used_cnt = 17'h10000;
			hint = '0;
			expected_rsp.delete();
			errors = 0;
			done = 0;
			pending = 0;
		end else begin
			if (cfg_we) page_count = cfg_wdata;
			if (in_valid && !in_stall) expected_rsp.push_back(serve_request(in_data));
			if (out_valid && !out_stall) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected transfer %p", $time, out_data);
					errors++;
				end else begin
					exp_rsp = expected_rsp.pop_front();
					if (out_data.status !== exp_rsp.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_rsp.status, out_data.status);
						errors++;
					end
					if (out_data.alloc_page !== exp_rsp.alloc_page) begin
						$display("%0t: alloc_page expected %0d actual %0d",
							$time, exp_rsp.alloc_page, out_data.alloc_page);
						errors++;
					end
					if (out_data.pages_in_use !== exp_rsp.pages_in_use) begin
						$display("%0t: pages_in_use expected %0d actual %0d",
							$time, exp_rsp.pages_in_use, out_data.pages_in_use);
						errors++;
					end
				end
				done++;
			end
			pending = expected_rsp.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import bpa_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [16:0] cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	req_t        in_data;
	logic        out_stall;
	logic        out_valid;
	rsp_t        out_data;

	int          errors;
	int          done;
	int          pending;
	int          sent;
	int          cycles;
	int          send_idle_pct;
	int          stall_pct;

	bitmap_page_allocator_next_fit_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	bpa_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.errors    (errors),
		.done      (done),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic send_request(logic op, logic [15:0] start, logic [16:0] len);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data.op <= op;
		in_data.start_page <= start;
		in_data.run_length <= len;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (done != sent) @(negedge clk);
	endtask

	task automatic write_page_count(logic [16:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_request(int unsigned total);
		logic [15:0] start;
		logic [16:0] len;
		int unsigned s;
		start = 16'($urandom);
		if ($urandom_range(1)) begin
			if ($urandom_range(99) < 85) begin
				len = 17'($urandom_range(1, (total < 8) ? 1 : total / 4));
			end else begin
				case ($urandom_range(3))
					0: len = 17'd0;
					1: len = 17'(total);
					2: len = 17'(total + 1);
					default: len = 17'($urandom);
				endcase
			end
			send_request(OP_ALLOC, start, len);
		end else begin
			if ($urandom_range(99) < 80) begin
				s = $urandom_range(0, total - 1);
				start = 16'(s);
				len = 17'($urandom_range(0, total - s));
			end else begin
				len = $urandom_range(1) ? 17'($urandom_range(0, total + 2)) : 17'($urandom);
			end
			send_request(OP_FREE, start, len);
		end
	endtask

	initial begin
		int unsigned sizes [6];
		sizes = '{1, 37, 64, 200, 256, 33};
		sent = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_page_count(17'h10000);
		send_request(OP_ALLOC, 16'h0000, 17'd0);
		send_request(OP_ALLOC, 16'hFFFF, 17'd1);
		send_request(OP_FREE, 16'hFFFF, 17'd2);
		send_request(OP_FREE, 16'h0000, 17'h1FFFF);
		send_request(OP_FREE, 16'hFFFF, 17'd1);
		send_request(OP_ALLOC, 16'h0000, 17'd1);
		send_request(OP_FREE, 16'h0010, 17'd0);
		send_request(OP_FREE, 16'h0000, 17'h10000);
		send_request(OP_ALLOC, 16'h0000, 17'h10000);
		send_request(OP_ALLOC, 16'h0000, 17'h10001);
		send_request(OP_FREE, 16'h0004, 17'd8);
		send_request(OP_ALLOC, 16'h0000, 17'd3);
		send_request(OP_ALLOC, 16'h0000, 17'd5);

		write_page_count(17'd0);
		send_request(OP_ALLOC, 16'h0000, 17'd1);
		send_request(OP_FREE, 16'h0000, 17'd1);
		send_request(OP_FREE, 16'h0000, 17'd0);
		send_request(OP_FREE, 16'h0005, 17'd0);

		write_page_count(17'd16);
		send_request(OP_FREE, 16'h000C, 17'd4);
		send_request(OP_ALLOC, 16'h0000, 17'd2);
		send_request(OP_FREE, 16'h0002, 17'd2);
		send_request(OP_ALLOC, 16'h0000, 17'd3);
		send_request(OP_FREE, 16'h0010, 17'd0);
		send_request(OP_ALLOC, 16'h0000, 17'd2);

		for (int ph = 0; ph < 6; ph++) begin
			write_page_count(17'(sizes[ph]));
			case (ph % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 52; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 52; end
				default: begin send_idle_pct = 18; stall_pct = 18; end
			endcase
			for (int i = 0; i < 130; i++) begin
				if (i == 65) drain();
				random_request(sizes[ph]);
			end
		end

		send_idle_pct = 0;
		stall_pct = 18;
		write_page_count(17'h1FFFF);
		send_request(OP_FREE, 16'h0000, 17'd64);
		for (int i = 0; i < 10; i++) random_request(64);

		drain();
		repeat (40) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
